// ===== rtl/bounded_set_table_macros.svh =====
// Assertion helpers used by the set table datapath.
// Each macro expects clk and rst to be visible where it is used.
`ifndef BOUNDED_SET_TABLE_MACROS_SVH
`define BOUNDED_SET_TABLE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bst_pkg.sv =====
package bst_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int ITEM_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  // Command codes. The unused code behaves as a query.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ITEM_W-1:0] item_value;
  } cmd_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COUNT_W-1:0] entry_count;
  } rsp_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic act;
    logic move_rd;
    logic move_wr;
    logic finish;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic miss_end;
    logic want_move;
    logic rsp_free;
  } ctl_stat_t;

endpackage

// ===== rtl/bst_regs.sv =====
module bst_regs
  import bst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CAP_W-1:0]   capacity_limit
);

  logic reg_sel;

  // Only bit 2 selects a register; the low bits are the byte offset.
  assign reg_sel = (paddr[2] == REG_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      capacity_limit <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(capacity_limit) : '0;

endmodule

// ===== rtl/bst_ctrl.sv =====
module bst_ctrl
  import bst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.hit || stat.miss_end) state <= S_ACT;
        end
        S_ACT: begin
          state <= stat.want_move ? S_MOVE_RD : S_FINISH;
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.rsp_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_ready   = (state == S_IDLE);
  assign ctl.start   = (state == S_IDLE) && cmd_valid;
  assign ctl.scan    = (state == S_SCAN);
  assign ctl.act     = (state == S_ACT);
  assign ctl.move_rd = (state == S_MOVE_RD);
  assign ctl.move_wr = (state == S_MOVE_WR);
  assign ctl.finish  = (state == S_FINISH) && stat.rsp_free;

endmodule

// ===== rtl/bst_datapath.sv =====
`include "bounded_set_table_macros.svh"

module bst_datapath
  import bst_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_word_t        cmd_word,
  input  logic [CAP_W-1:0] capacity_limit,
  input  ctl_cmd_t         ctl,
  output ctl_stat_t        stat,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_word_t        rsp_word
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] key_in;
  logic [CMD_W-1:0]       cmd_code;
  logic [CNT_W-1:0]       live_count;
  logic [CNT_W-1:0]       scan_idx;
  logic                   chk_valid;
  logic [AW-1:0]          chk_idx;
  logic                   found;
  logic [AW-1:0]          hit_slot;
  logic [STAT_W-1:0]      res_status;
  logic [STAT_W-1:0]      res_status_next;

  logic                   issue;
  logic                   match;
  logic                   full;
  logic                   is_insert;
  logic                   is_erase;
  logic                   want_append;
  logic [AW-1:0]          last_idx;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  if (VALUE_WIDTH <= ITEM_W) begin : gen_key_narrow
    assign key_in = cmd_word.item_value[VALUE_WIDTH-1:0];
  end else begin : gen_key_wide
    assign key_in = {{(VALUE_WIDTH - ITEM_W){1'b0}}, cmd_word.item_value};
  end

  assign issue     = (scan_idx < live_count);
  assign match     = chk_valid && (rdata == key);
  assign is_insert = (cmd_code == CMD_INSERT);
  assign is_erase  = (cmd_code == CMD_ERASE);
  assign full      = (CMP_W'(live_count) >= CMP_W'(capacity_limit)) ||
                     (live_count >= CNT_W'(DEPTH));
  assign want_append = is_insert && !found && !full;
  assign last_idx  = AW'(live_count - CNT_W'(1));

  assign stat.hit       = match;
  assign stat.miss_end  = !chk_valid && !issue;
  assign stat.want_move = is_erase && found;
  assign stat.rsp_free  = !rsp_valid || rsp_ready;

  // One read port and one write port, shared by the search, the append and the swap with the last entry.
  assign rd_addr = ctl.move_rd ? last_idx : scan_idx[AW-1:0];
  assign mem_we  = (ctl.act && want_append) || ctl.move_wr;
  assign wr_addr = ctl.move_wr ? hit_slot : live_count[AW-1:0];
  assign wr_data = ctl.move_wr ? rdata : key;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_comb begin
    res_status_next = ST_MISSING;
    if (is_insert) begin
      if (found) res_status_next = ST_PRESENT;
      else if (full) res_status_next = ST_FULL;
      else res_status_next = ST_DONE;
    end else begin
      res_status_next = found ? ST_DONE : ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      chk_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (ctl.start) begin
        key       <= key_in;
        cmd_code  <= cmd_word.cmd;
        scan_idx  <= '0;
        chk_valid <= 1'b0;
        found     <= 1'b0;
      end
      if (ctl.scan) begin
        scan_idx  <= scan_idx + CNT_W'(issue);
        chk_valid <= issue;
        chk_idx   <= scan_idx[AW-1:0];
        if (match) begin
          found    <= 1'b1;
          hit_slot <= chk_idx;
        end
      end
      if (ctl.act) begin
        res_status <= res_status_next;
        if (want_append) live_count <= live_count + CNT_W'(1);
      end
      if (ctl.move_wr) begin
        live_count <= live_count - CNT_W'(1);
      end
      if (ctl.finish) begin
        rsp_valid            <= 1'b1;
        rsp_word.status      <= res_status;
        rsp_word.found       <= found;
        rsp_word.entry_count <= COUNT_W'(live_count);
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `BST_ASSERT_IMP(a_count_bound, 1'b1, live_count <= CNT_W'(DEPTH), "live count past depth")
  `BST_ASSERT_IMP(a_append_room, ctl.act && want_append, live_count < CNT_W'(DEPTH) && !found, "append without room")
  `BST_ASSERT_NXT(a_move_shrinks, ctl.move_wr, live_count == $past(live_count) - CNT_W'(1), "erase did not shrink")
  `BST_ASSERT_IMP(a_no_overwrite, ctl.finish, !rsp_valid || rsp_ready, "result overwritten")

endmodule

// ===== rtl/bounded_set_table.sv =====
// Set of distinct values held in an unordered table with a live count.
// Command channel (cmd_valid, cmd_ready, cmd_word): each word carries an
// operation (insert, erase or membership query) and the value it acts on.
// Result channel (rsp_valid, rsp_ready, rsp_word): exactly one word per
// command, giving a status, whether the value was present beforehand and
// the entry count after the command.
// The capacity limit register sits at byte address 0 of the APB port.
// A command walks the table one entry per cycle through the memory read
// port. A miss scans every live entry and a hit in slot s ends the search
// there; an erase that hits then moves the last entry into the freed slot,
// so the slowest command is an erase of the last entry of a full table.
// The block works on one command at a time and accepts the next one in the
// cycle after the previous result is registered.
// The result sits in an output register; if the receiver stalls, the next
// command is still searched and waits only for that register to empty.
// Reset empties the set and sets the capacity limit to 64; table contents
// need no clearing, since only entries below the live count are read.
module bounded_set_table
  import bst_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_word_t          cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_word_t          rsp_word
);

  logic [CAP_W-1:0] capacity_limit;
  ctl_cmd_t         ctl;
  ctl_stat_t        stat;

  // Configuration register file.
  bst_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .capacity_limit (capacity_limit)
  );

  // Sequencer: search, act, optional swap, then hand off the result.
  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Table memory, count, comparator and result register.
  bst_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd_word       (cmd_word),
    .capacity_limit (capacity_limit),
    .ctl            (ctl),
    .stat           (stat),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp_word       (rsp_word)
  );

endmodule
